>>> design/image_upscale_2x_linear_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x linear upscaler
// Concurrent assertions on the rising edge of clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_UPSCALE_2X_LINEAR_ASSERT_SVH
`define IMAGE_UPSCALE_2X_LINEAR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define IU2X_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define IU2X_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IU2X_ASSERT_SAME(name, ante, cons, msg)

`define IU2X_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

>>> design/iu2x_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iu2x_pkg
// Shared types, register indexes and defaults of the 2x linear upscaler.
// ----------------------------------------------------------------------------
package iu2x_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_PIXEL_BITS = 16;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_DIM_W   = 11;
	localparam int OUT_COORD_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH,
		CFG_SRC_HEIGHT,
		CFG_WIDTH_TRIM,
		CFG_HEIGHT_TRIM
	} cfg_index_t;

	typedef struct packed {
		logic [CFG_DIM_W-1:0] src_width;
		logic [CFG_DIM_W-1:0] src_height;
		logic                 width_trim;
		logic                 height_trim;
	} cfg_regs_t;

	// Output row relative to the source row: the odd row above, the even row,
	// and the replicated row below the last source row.
	typedef enum logic [1:0] {
		ROW_ABOVE,
		ROW_EVEN,
		ROW_BELOW
	} row_sel_t;

	// Output column relative to the source column.
	typedef enum logic [1:0] {
		COL_LEFT,
		COL_HERE,
		COL_REPL
	} col_sel_t;

	typedef struct packed {
		logic has_left;
		logic rep_col;
		logic odd_row;
		logic extra_row;
		logic frame_last;
	} item_flags_t;

endpackage

>>> design/iu2x_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iu2x channel interfaces
// Source pixel channel and tagged output pixel channel, valid/ready.
// ----------------------------------------------------------------------------
interface iu2x_pix_if #(
	parameter int PIXEL_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

interface iu2x_res_if #(
	parameter int PIXEL_BITS = 16,
	parameter int COORD_W    = 11
);
	logic                  valid;
	logic                  ready;
	logic [COORD_W-1:0]    out_col;
	logic [COORD_W-1:0]    out_row;
	logic [PIXEL_BITS-1:0] out_value;
	logic                  run_last;
	logic                  frame_end;

	modport source (output valid, output out_col, output out_row, output out_value,
		output run_last, output frame_end, input ready);
	modport sink   (input valid, input out_col, input out_row, input out_value,
		input run_last, input frame_end, output ready);
endinterface

>>> design/iu2x_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iu2x_cfg
// Configuration register file with an indexed write port.
// ----------------------------------------------------------------------------
module iu2x_cfg
	import iu2x_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_regs_t             regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.src_width   <= CFG_DIM_W'(1);
			regs_q.src_height  <= CFG_DIM_W'(1);
			regs_q.width_trim  <= 1'b0;
			regs_q.height_trim <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SRC_WIDTH:   regs_q.src_width   <= cfg_wdata[CFG_DIM_W-1:0];
				CFG_SRC_HEIGHT:  regs_q.src_height  <= cfg_wdata[CFG_DIM_W-1:0];
				CFG_WIDTH_TRIM:  regs_q.width_trim  <= cfg_wdata[0];
				CFG_HEIGHT_TRIM: regs_q.height_trim <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> design/iu2x_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iu2x_front
// Position counters, previous-row line memory and the input stage register.
// ----------------------------------------------------------------------------
module iu2x_front
	import iu2x_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int CNT_W     = $clog2(MAX_WIDTH),
	localparam int RCNT_W    = $clog2(MAX_HEIGHT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_regs_t             regs,
	iu2x_pix_if.sink              src,
	input  logic                  take_s1,
	output logic                  valid_s1,
	output item_flags_t           flags_s1,
	output logic [CNT_W-1:0]      col_s1,
	output logic [RCNT_W-1:0]     row_s1,
	output logic [PIXEL_BITS-1:0] pix_s1,
	output logic [PIXEL_BITS-1:0] mid_s1,
	output logic [PIXEL_BITS-1:0] up_s1,
	output logic [PIXEL_BITS-1:0] up_left_s1
);

	localparam int DW = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ? $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
	localparam int DH = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ? $clog2(MAX_HEIGHT + 1)
		: CFG_DIM_W;

	logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

	logic [CNT_W-1:0]      col_q;
	logic [RCNT_W-1:0]     row_q;
	logic [PIXEL_BITS-1:0] left_q;
	logic                  valid_q;

	logic [DW-1:0]       w_ext;
	logic [DW-1:0]       w_m1;
	logic [DH-1:0]       h_ext;
	logic [DH-1:0]       h_m1;
	logic                last_c;
	logic                last_r;
	logic                accept;
	logic [PIXEL_BITS:0] mid_sum;
	item_flags_t         flags;

	always_comb begin
		w_ext = DW'(regs.src_width);
		h_ext = DH'(regs.src_height);
		if (w_ext == '0) begin
			w_m1 = '0;
		end else if (w_ext > DW'(MAX_WIDTH)) begin
			w_m1 = DW'(MAX_WIDTH - 1);
		end else begin
			w_m1 = w_ext - DW'(1);
		end
		if (h_ext == '0) begin
			h_m1 = '0;
		end else if (h_ext > DH'(MAX_HEIGHT)) begin
			h_m1 = DH'(MAX_HEIGHT - 1);
		end else begin
			h_m1 = h_ext - DH'(1);
		end
		last_c = DW'(col_q) >= w_m1;
		last_r = DH'(row_q) >= h_m1;
		flags.has_left   = col_q != '0;
		flags.rep_col    = last_c && !regs.width_trim;
		flags.odd_row    = row_q != '0;
		flags.extra_row  = last_r && !regs.height_trim;
		flags.frame_last = last_c && last_r;
		mid_sum = {1'b0, left_q} + {1'b0, src.pixel_value};
	end

	assign src.ready = !valid_q || take_s1;
	assign accept    = src.valid && src.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_q <= 1'b1;
				if (last_c) begin
					col_q <= '0;
					row_q <= last_r ? '0 : row_q + RCNT_W'(1);
				end else begin
					col_q <= col_q + CNT_W'(1);
				end
			end else if (take_s1) begin
				valid_q <= 1'b0;
			end
		end
	end

	// The line memory is read before it is overwritten at the same column, so
	// the stage sees the pixel of the previous row. The read of the previous
	// column moves on to up_left_s1.
	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1             <= line_mem[col_q];
			line_mem[col_q]   <= src.pixel_value;
			up_left_s1        <= up_s1;
			left_q            <= src.pixel_value;
			pix_s1            <= src.pixel_value;
			mid_s1            <= mid_sum[PIXEL_BITS:1];
			col_s1            <= col_q;
			row_s1            <= row_q;
			flags_s1          <= flags;
		end
	end

	assign valid_s1 = valid_q;

endmodule

>>> design/iu2x_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iu2x_expand
// Walks the output pixels of the staged source pixel, one per cycle while
// dst is not stalled, into the output register.
// ----------------------------------------------------------------------------
module iu2x_expand
	import iu2x_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int CNT_W     = $clog2(MAX_WIDTH),
	localparam int RCNT_W    = $clog2(MAX_HEIGHT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  item_flags_t           flags_s1,
	input  logic [CNT_W-1:0]      col_s1,
	input  logic [RCNT_W-1:0]     row_s1,
	input  logic [PIXEL_BITS-1:0] pix_s1,
	input  logic [PIXEL_BITS-1:0] mid_s1,
	input  logic [PIXEL_BITS-1:0] up_s1,
	input  logic [PIXEL_BITS-1:0] up_left_s1,
	output logic                  take_s1,
	iu2x_res_if.source            dst
);

	localparam int XW = (CNT_W + 2 > OUT_COORD_W) ? CNT_W + 2 : OUT_COORD_W;
	localparam int YW = (RCNT_W + 2 > OUT_COORD_W) ? RCNT_W + 2 : OUT_COORD_W;

	row_sel_t row_sel_q;
	col_sel_t col_sel_q;
	logic     started_q;
	logic     out_valid_q;

	logic [OUT_COORD_W-1:0] out_col_q;
	logic [OUT_COORD_W-1:0] out_row_q;
	logic [PIXEL_BITS-1:0]  out_value_q;
	logic                   run_last_q;
	logic                   frame_end_q;

	row_sel_t            cur_r;
	row_sel_t            first_r;
	row_sel_t            last_r;
	col_sel_t            cur_c;
	col_sel_t            first_c;
	col_sel_t            last_c;
	logic                is_last;
	logic                load;
	logic [PIXEL_BITS:0] sum_up;
	logic [PIXEL_BITS:0] sum_pair;
	logic [PIXEL_BITS:0] sum_odd;
	logic [PIXEL_BITS-1:0] avg_up;
	logic [PIXEL_BITS-1:0] avg_pair;
	logic [PIXEL_BITS-1:0] odd_mid;
	logic [PIXEL_BITS-1:0] value;
	logic [XW-1:0]       x_full;
	logic [YW-1:0]       y_full;

	always_comb begin
		first_r = flags_s1.odd_row ? ROW_ABOVE : ROW_EVEN;
		last_r  = flags_s1.extra_row ? ROW_BELOW : ROW_EVEN;
		first_c = flags_s1.has_left ? COL_LEFT : COL_HERE;
		last_c  = flags_s1.rep_col ? COL_REPL : COL_HERE;
		cur_r   = started_q ? row_sel_q : first_r;
		cur_c   = started_q ? col_sel_q : first_c;
		is_last = (cur_r == last_r) && (cur_c == last_c);

		sum_up   = {1'b0, up_s1} + {1'b0, pix_s1};
		avg_up   = sum_up[PIXEL_BITS:1];
		sum_pair = {1'b0, up_left_s1} + {1'b0, up_s1};
		avg_pair = sum_pair[PIXEL_BITS:1];
		sum_odd  = {1'b0, avg_pair} + {1'b0, mid_s1};
		odd_mid  = sum_odd[PIXEL_BITS:1];

		case (cur_r)
			ROW_ABOVE: value = (cur_c == COL_LEFT) ? odd_mid : avg_up;
			default:   value = (cur_c == COL_LEFT) ? mid_s1 : pix_s1;
		endcase

		x_full = (XW'(col_s1) << 1) + XW'(cur_c) - XW'(1);
		y_full = (YW'(row_s1) << 1) + YW'(cur_r) - YW'(1);
	end

	assign load    = valid_s1 && (!out_valid_q || dst.ready);
	assign take_s1 = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			row_sel_q   <= ROW_ABOVE;
			col_sel_q   <= COL_LEFT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (is_last) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					if (cur_c == last_c) begin
						row_sel_q <= row_sel_t'(cur_r + 2'd1);
						col_sel_q <= first_c;
					end else begin
						row_sel_q <= cur_r;
						col_sel_q <= col_sel_t'(cur_c + 2'd1);
					end
				end
			end else if (dst.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_col_q   <= x_full[OUT_COORD_W-1:0];
			out_row_q   <= y_full[OUT_COORD_W-1:0];
			out_value_q <= value;
			run_last_q  <= is_last;
			frame_end_q <= is_last && flags_s1.frame_last;
		end
	end

	assign dst.valid     = out_valid_q;
	assign dst.out_col   = out_col_q;
	assign dst.out_row   = out_row_q;
	assign dst.out_value = out_value_q;
	assign dst.run_last  = run_last_q;
	assign dst.frame_end = frame_end_q;

endmodule

>>> design/image_upscale_2x_linear.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_upscale_2x_linear
// Doubles a raster image by linear interpolation and emits each output pixel
// tagged with its destination column and row.
//
//   Channel   Direction  Transfer carries
//   src       in         pixel_value
//   dst       out        out_col, out_row, out_value, run_last, frame_end
//   cfg       in         cfg_index, cfg_wdata when cfg_we is high
//
// Each source pixel yields 1 to 9 output pixels, four for an interior one;
// the output register takes one per cycle while dst is not stalled, and a
// pixel holds the stage until its last output is loaded; the next pixel
// transfers in that same cycle. A first output passes the input stage
// register, then the output register. Reset clears the counters and the
// handshakes, not the row memory. Stalls on dst hold the stage, then src.
// ----------------------------------------------------------------------------
`include "image_upscale_2x_linear_assert.svh"

module image_upscale_2x_linear
	import iu2x_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	iu2x_pix_if.sink              src,
	iu2x_res_if.source            dst
);

	localparam int CNT_W  = $clog2(MAX_WIDTH);
	localparam int RCNT_W = $clog2(MAX_HEIGHT);

	cfg_regs_t             regs;
	logic                  take_s1;
	logic                  valid_s1;
	item_flags_t           flags_s1;
	logic [CNT_W-1:0]      col_s1;
	logic [RCNT_W-1:0]     row_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [PIXEL_BITS-1:0] mid_s1;
	logic [PIXEL_BITS-1:0] up_s1;
	logic [PIXEL_BITS-1:0] up_left_s1;

	iu2x_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.regs      (regs)
	);

	iu2x_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.src        (src),
		.take_s1    (take_s1),
		.valid_s1   (valid_s1),
		.flags_s1   (flags_s1),
		.col_s1     (col_s1),
		.row_s1     (row_s1),
		.pix_s1     (pix_s1),
		.mid_s1     (mid_s1),
		.up_s1      (up_s1),
		.up_left_s1 (up_left_s1)
	);

	iu2x_expand #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.flags_s1   (flags_s1),
		.col_s1     (col_s1),
		.row_s1     (row_s1),
		.pix_s1     (pix_s1),
		.mid_s1     (mid_s1),
		.up_s1      (up_s1),
		.up_left_s1 (up_left_s1),
		.take_s1    (take_s1),
		.dst        (dst)
	);

	`IU2X_ASSERT_NEXT(a_accept_fills_stage, src.valid && src.ready, valid_s1, "stage empty after transfer")
	`IU2X_ASSERT_NEXT(a_take_marks_last, take_s1, dst.valid && dst.run_last, "run_last missing")
	`IU2X_ASSERT_SAME(a_take_needs_item, take_s1, valid_s1, "stage freed while empty")
	`IU2X_ASSERT_SAME(a_frame_end_last, dst.valid && dst.frame_end, dst.run_last, "frame_end without run_last")

endmodule
